// ===== rtl/core/smeu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smeu_pkg
// shared types and codes for the stack machine execute unit
// ----------------------------------------------------------------------------
package smeu_pkg;

	typedef enum logic [4:0] {
		OP_PUSH = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_DIV = 5'd3, OP_MUL = 5'd4,
		OP_MOD = 5'd5, OP_LT = 5'd6, OP_LE = 5'd7, OP_GT = 5'd8, OP_GE = 5'd9,
		OP_EQ = 5'd10, OP_NE = 5'd11, OP_NOT = 5'd12, OP_DUP = 5'd13, OP_DUMP = 5'd14,
		OP_JMP = 5'd15, OP_JZ = 5'd16, OP_JNZ = 5'd17, OP_HALT = 5'd18
	} opcode_t;

	typedef enum logic [3:0] {
		ST_OK = 4'd0, ST_HALTED = 4'd1, ST_OVERFLOW = 4'd2, ST_UNDERFLOW = 4'd3,
		ST_BAD_INDEX = 4'd4, ST_BAD_ADDR = 4'd5, ST_ILLEGAL = 4'd6,
		ST_DIV_ZERO = 4'd7, ST_IGNORED = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		ALU_MUL = 2'd0, ALU_DIV = 2'd1, ALU_MOD = 2'd2
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/smeu_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smeu_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module smeu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/smeu_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smeu_alu
// iterative multiplier and signed divider, one bit per cycle
// ----------------------------------------------------------------------------
module smeu_alu (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire smeu_pkg::alu_ctl_t ctl,
	input  wire  [63:0]             b,
	input  wire  [63:0]             a,
	output logic                    done,
	output logic [63:0]             result
);

	logic [6:0]       cnt_q;
	logic             busy_q;
	smeu_pkg::alu_op_t op_q;
	logic [63:0]      acc_q;
	logic [63:0]      md_q;
	logic [63:0]      qt_q;
	logic             neg_q_q;
	logic             neg_r_q;
	logic [64:0]      trial;
	logic [63:0]      rem_sh;
	logic [63:0]      mag_b;
	logic [63:0]      mag_a;

	assign mag_b = b[63] ? (~b + 64'd1) : b;
	assign mag_a = a[63] ? (~a + 64'd1) : a;
	assign rem_sh = {acc_q[62:0], qt_q[63]};
	assign trial = {1'b0, rem_sh} - {1'b0, md_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q  <= 1'b1;
				cnt_q   <= '0;
				op_q    <= ctl.op;
				neg_q_q <= b[63] ^ a[63];
				neg_r_q <= b[63];
				acc_q   <= '0;
				if (ctl.op == smeu_pkg::ALU_MUL) begin
					md_q <= b;
					qt_q <= a;
				end else begin
					md_q <= mag_a;
					qt_q <= mag_b;
				end
			end else if (busy_q) begin
				if (cnt_q == 7'd64) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
					case (op_q)
						smeu_pkg::ALU_MUL: result <= acc_q;
						smeu_pkg::ALU_DIV: result <= neg_q_q ? (~qt_q + 64'd1) : qt_q;
						default:           result <= neg_r_q ? (~acc_q + 64'd1) : acc_q;
					endcase
				end else begin
					cnt_q <= cnt_q + 7'd1;
					if (op_q == smeu_pkg::ALU_MUL) begin
						acc_q <= (acc_q << 1) + (qt_q[63] ? md_q : 64'd0);
						qt_q  <= qt_q << 1;
					end else if (!trial[64]) begin
						acc_q <= trial[63:0];
						qt_q  <= {qt_q[62:0], 1'b1};
					end else begin
						acc_q <= rem_sh;
						qt_q  <= {qt_q[62:0], 1'b0};
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/stack_machine_execute_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// executes one instruction per beat on a 64-bit data stack
// ----------------------------------------------------------------------------
// states: stopped or fetch out of range go from idle straight to out; push, dup, jmp,
// halt and illegal pass popa and fin; ops that pop add popb, and waitb for a second
// pop (one ram read per pop); multiply, divide and remainder add s_alu on the shared alu
// throughput: one beat at a time, next beat accepted in the cycle after the result is
// registered; the result register frees the input side
// reset: asynchronous, pointer, depth and stopped flag clear; stack ram holds
// no reset and its data is used only where written
module stack_machine_execute_unit #(
	parameter int STACK_DEPTH = 1024,
	parameter int IP_BITS     = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [16:0] cfg_data,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [71:0] s_tdata,   // req_type[4:0], operand[68:5], zero pad
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [103:0] m_tdata   // status, next_ip, depth_now, dump_valid, dump_value
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam logic [16:0] CAP = (IP_BITS >= 17) ? 17'h1ffff : 17'(1 << IP_BITS);
	localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE, S_POPA, S_POPB, S_WAITB, S_ALU, S_FIN, S_OUT
	} state_t;

	state_t           state_q;
	logic [16:0]      plen_q;
	logic [16:0]      ip_q;
	logic [DW-1:0]    dep_q;
	logic             stop_q;
	logic [4:0]       op_q;
	logic [63:0]      arg_q;
	logic [63:0]      a_q;
	logic [63:0]      b_q;
	logic             ram_we;
	logic [AW-1:0]    ram_addr;
	logic [63:0]      ram_wdata;
	logic [63:0]      ram_rdata;
	smeu_pkg::alu_ctl_t alu_ctl;
	logic             alu_done;
	logic [63:0]      alu_res;
	logic [16:0]      lim;
	logic [3:0]       st_q;
	logic             dv_q;
	logic             wr_q;
	logic [63:0]      wv_q;
	logic [16:0]      tgt;
	logic             tgt_ok;

	assign lim = (plen_q > CAP) ? CAP : plen_q;
	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == S_IDLE);
	assign tgt = 17'(arg_q[16:0]);
	assign tgt_ok = (arg_q[63:17] == '0) && (tgt < lim);

	smeu_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	smeu_alu u_alu (
		.clk(clk), .arst_n(arst_n), .ctl(alu_ctl), .b(ram_rdata), .a(a_q),
		.done(alu_done), .result(alu_res)
	);

	always_comb begin
		ram_we    = wr_q && (state_q == S_FIN);
		ram_wdata = wv_q;
		ram_addr  = AW'(dep_q);
		if (state_q == S_IDLE || state_q == S_POPA || state_q == S_POPB) begin
			ram_addr = AW'(dep_q - DW'(1));
		end
		if (state_q == S_IDLE && s_tdata[4:0] == smeu_pkg::OP_DUP) begin
			ram_addr = AW'(s_tdata[68:5]);
		end
		alu_ctl.start = 1'b0;
		alu_ctl.op    = smeu_pkg::ALU_MUL;
		if (state_q == S_WAITB && (op_q == smeu_pkg::OP_MUL || op_q == smeu_pkg::OP_DIV
				|| op_q == smeu_pkg::OP_MOD) && !(op_q != smeu_pkg::OP_MUL && a_q == '0)) begin
			alu_ctl.start = 1'b1;
			alu_ctl.op = (op_q == smeu_pkg::OP_MUL) ? smeu_pkg::ALU_MUL :
				(op_q == smeu_pkg::OP_DIV) ? smeu_pkg::ALU_DIV : smeu_pkg::ALU_MOD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			plen_q   <= 17'h10000;
			ip_q     <= '0;
			dep_q    <= '0;
			stop_q   <= 1'b0;
			m_tvalid <= 1'b0;
			wr_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				plen_q <= cfg_data;
			end
			if (m_tvalid && m_tready && state_q != S_OUT) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q  <= s_tdata[4:0];
						arg_q <= s_tdata[68:5];
						st_q  <= smeu_pkg::ST_OK;
						dv_q  <= 1'b0;
						wr_q  <= 1'b0;
						if (stop_q) begin
							st_q    <= smeu_pkg::ST_IGNORED;
							state_q <= S_OUT;
						end else if (ip_q >= lim) begin
							st_q    <= smeu_pkg::ST_BAD_ADDR;
							stop_q  <= 1'b1;
							state_q <= S_OUT;
						end else begin
							ip_q    <= ip_q + 17'd1;
							state_q <= S_POPA;
						end
					end
				end
				S_POPA: begin
					// ram data here is top of stack, or the dup entry
					state_q <= S_FIN;
					if (op_q <= smeu_pkg::OP_NE && op_q != smeu_pkg::OP_PUSH
							|| op_q == smeu_pkg::OP_NOT
							|| op_q == smeu_pkg::OP_DUMP || op_q == smeu_pkg::OP_JZ
							|| op_q == smeu_pkg::OP_JNZ) begin
						if (dep_q == '0) begin
							st_q <= smeu_pkg::ST_UNDERFLOW;
						end else begin
							dep_q <= dep_q - DW'(1);
							a_q   <= ram_rdata;
							state_q <= S_POPB;
						end
					end else begin
						case (op_q)
							smeu_pkg::OP_PUSH: begin
								if (dep_q >= FULL) st_q <= smeu_pkg::ST_OVERFLOW;
								else begin wr_q <= 1'b1; wv_q <= arg_q; end
							end
							smeu_pkg::OP_DUP: begin
								if (arg_q >= 64'(dep_q)) st_q <= smeu_pkg::ST_BAD_INDEX;
								else if (dep_q >= FULL) st_q <= smeu_pkg::ST_OVERFLOW;
								else begin wr_q <= 1'b1; wv_q <= ram_rdata; end
							end
							smeu_pkg::OP_JMP: begin
								if (!tgt_ok) st_q <= smeu_pkg::ST_BAD_ADDR;
								else ip_q <= tgt;
							end
							smeu_pkg::OP_HALT: st_q <= smeu_pkg::ST_HALTED;
							default: st_q <= smeu_pkg::ST_ILLEGAL;
						endcase
					end
				end
				S_POPB: begin
					state_q <= S_FIN;
					case (op_q)
						smeu_pkg::OP_NOT: begin
							wr_q <= 1'b1;
							wv_q <= {63'd0, a_q == '0};
						end
						smeu_pkg::OP_DUMP: dv_q <= 1'b1;
						smeu_pkg::OP_JZ, smeu_pkg::OP_JNZ: begin
							if ((op_q == smeu_pkg::OP_JZ) == (a_q == '0)) begin
								if (!tgt_ok) st_q <= smeu_pkg::ST_BAD_ADDR;
								else ip_q <= tgt;
							end
						end
						default: begin
							if (dep_q == '0) begin
								st_q <= smeu_pkg::ST_UNDERFLOW;
							end else begin
								dep_q   <= dep_q - DW'(1);
								state_q <= S_WAITB;
							end
						end
					endcase
				end
				S_WAITB: begin
					state_q <= S_FIN;
					wr_q    <= 1'b1;
					case (op_q)
						smeu_pkg::OP_ADD: wv_q <= ram_rdata + a_q;
						smeu_pkg::OP_SUB: wv_q <= ram_rdata - a_q;
						smeu_pkg::OP_LT:  wv_q <= {63'd0, $signed(ram_rdata) < $signed(a_q)};
						smeu_pkg::OP_LE:  wv_q <= {63'd0, $signed(ram_rdata) <= $signed(a_q)};
						smeu_pkg::OP_GT:  wv_q <= {63'd0, $signed(ram_rdata) > $signed(a_q)};
						smeu_pkg::OP_GE:  wv_q <= {63'd0, $signed(ram_rdata) >= $signed(a_q)};
						smeu_pkg::OP_EQ:  wv_q <= {63'd0, ram_rdata == a_q};
						smeu_pkg::OP_NE:  wv_q <= {63'd0, ram_rdata != a_q};
						default: begin
							if (op_q != smeu_pkg::OP_MUL && a_q == '0) begin
								wr_q <= 1'b0;
								st_q <= smeu_pkg::ST_DIV_ZERO;
							end else begin
								state_q <= S_ALU;
							end
						end
					endcase
				end
				S_ALU: begin
					if (alu_done) begin
						wv_q    <= alu_res;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (wr_q) begin
						dep_q <= dep_q + DW'(1);
					end
					if (st_q != smeu_pkg::ST_OK) begin
						stop_q <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {7'd0, dv_q ? a_q : 64'd0, dv_q, 11'(dep_q), ip_q, st_q};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_depth_max: assert property (@(posedge clk) disable iff (!arst_n) dep_q <= FULL)
		else $error("depth beyond capacity");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("accepted while busy");
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		$past(stop_q) |-> stop_q)
		else $error("stopped flag cleared");
`endif

endmodule
`default_nettype wire
